>>> sv/cfm_pkg.sv
// Shared constants for the coverage feedback merge unit.
package cfm_pkg;

    localparam int unsigned IDX_W           = 16;
    localparam int unsigned HIT_W           = 8;
    localparam int unsigned OP_W            = 8;
    localparam int unsigned OPND_W          = 64;
    localparam int unsigned CMD_W           = 2;
    localparam int unsigned VERDICT_W       = 2;

    localparam int unsigned MAP_ENTRIES_DEF = 65536;
    localparam int unsigned ID_SPACE_DEF    = 65536;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_COV   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

    // Result kinds
    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Run flag bits
    localparam int unsigned FLAG_COV   = 0;
    localparam int unsigned FLAG_STATE = 1;

endpackage

>>> sv/cfm_index_reduce.sv
// Two-stage reduction of a 16-bit index modulo a constant table depth.
module cfm_index_reduce #(
    parameter int unsigned MOD = cfm_pkg::MAP_ENTRIES_DEF,
    localparam int unsigned AW = $clog2(MOD)
) (
    input  logic                      aclk,
    input  logic [cfm_pkg::IDX_W-1:0] idx,
    output logic [AW-1:0]             rem
);

    localparam int unsigned IW = cfm_pkg::IDX_W;

    generate
        if (MOD >= (1 << IW)) begin : g_pass
            // index always in range: just delay to match the reducing path
            logic [IW-1:0] idx_d_reg;
            logic [AW-1:0] rem_reg;

            always_ff @(posedge aclk) begin
                idx_d_reg <= idx;
                rem_reg   <= AW'(idx_d_reg);
            end

            assign rem = rem_reg;
        end else begin : g_reduce
            // q = floor(idx * (floor(2^32 / MOD) + 1) / 2^32) is exact for idx < 2^16
            localparam int unsigned SH     = 32;
            localparam logic [SH:0] RECIP  = (SH+1)'((64'd1 << SH) / MOD + 1);
            localparam logic [IW:0] MOD_C  = (IW+1)'(MOD);
            localparam int unsigned PROD_W = IW + SH + 1;

            logic [PROD_W-1:0] prod_reg;
            logic [IW-1:0]     idx_d_reg;
            logic [AW-1:0]     rem_reg;
            logic [IW:0]       quot;
            logic [2*IW+1:0]   qm;
            logic [IW:0]       diff;

            always_comb begin
                quot = prod_reg[PROD_W-1:SH];
                qm   = quot * MOD_C;
                diff = {1'b0, idx_d_reg} - qm[IW:0];
            end

            always_ff @(posedge aclk) begin
                prod_reg  <= PROD_W'(idx) * PROD_W'(RECIP);
                idx_d_reg <= idx;
                rem_reg   <= diff[AW-1:0];
            end

            assign rem = rem_reg;
        end
    endgenerate

endmodule

>>> sv/cfm_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module cfm_ram #(
    parameter int unsigned DEPTH = cfm_pkg::MAP_ENTRIES_DEF,
    parameter int unsigned WIDTH = cfm_pkg::HIT_W,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/coverage_feedback_merge_unit.sv
// Coverage feedback merge unit: coverage map merge and new-state record filter.
// Item path: latch, first and second index reduce, RAM read, update, registered result.
// A new item is taken only in the idle state, once the read-modify-write of the last
//   entry (index reduction, registered read, compare and write back) has committed.
// Reset: flags and control clear at once; then a clearing pass over every entry
//   zeroes both RAMs while s_ready stays low.
module coverage_feedback_merge_unit #(
    parameter int unsigned MAP_ENTRIES = cfm_pkg::MAP_ENTRIES_DEF,
    parameter int unsigned ID_SPACE    = cfm_pkg::ID_SPACE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cfm_pkg::CMD_W-1:0]     s_command,
    input  logic [cfm_pkg::IDX_W-1:0]     s_cov_index,
    input  logic [cfm_pkg::HIT_W-1:0]     s_cov_value,
    input  logic [cfm_pkg::IDX_W-1:0]     s_state_id,
    input  logic [cfm_pkg::OP_W-1:0]      s_state_op,
    input  logic [cfm_pkg::OPND_W-1:0]    s_left_operand,
    input  logic [cfm_pkg::OPND_W-1:0]    s_right_operand,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_result_kind,
    output logic [cfm_pkg::IDX_W-1:0]     m_out_id,
    output logic [cfm_pkg::OP_W-1:0]      m_out_op,
    output logic [cfm_pkg::OPND_W-1:0]    m_out_left,
    output logic [cfm_pkg::OPND_W-1:0]    m_out_right,
    output logic [cfm_pkg::VERDICT_W-1:0] m_verdict
);

    localparam int unsigned MAP_AW  = $clog2(MAP_ENTRIES);
    localparam int unsigned ID_AW   = $clog2(ID_SPACE);
    localparam int unsigned CLR_LEN = (MAP_ENTRIES > ID_SPACE) ? MAP_ENTRIES : ID_SPACE;
    localparam int unsigned CLR_W   = $clog2(CLR_LEN);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;  // post-reset RAM zeroing
    localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for an item
    localparam logic [2:0] ST_MUL   = 3'd2;  // index reduce, first stage
    localparam logic [2:0] ST_REM   = 3'd3;  // index reduce, second stage
    localparam logic [2:0] ST_RD    = 3'd4;  // RAM read issued
    localparam logic [2:0] ST_UPD   = 3'd5;  // compare, write back, emit

    logic [2:0]       state_reg, state_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [cfm_pkg::VERDICT_W-1:0] flags_reg, flags_next;

    // Latched item fields (payload, no reset)
    logic [cfm_pkg::CMD_W-1:0]  cmd_reg;
    logic [cfm_pkg::IDX_W-1:0]  cov_index_reg;
    logic [cfm_pkg::HIT_W-1:0]  hit_reg;
    logic [cfm_pkg::IDX_W-1:0]  state_id_reg;
    logic [cfm_pkg::OP_W-1:0]   op_reg;
    logic [cfm_pkg::OPND_W-1:0] left_reg;
    logic [cfm_pkg::OPND_W-1:0] right_reg;

    // Output register
    logic                          m_valid_reg, m_valid_next;
    logic                          kind_reg;
    logic [cfm_pkg::IDX_W-1:0]     out_id_reg;
    logic [cfm_pkg::OP_W-1:0]      out_op_reg;
    logic [cfm_pkg::OPND_W-1:0]    out_left_reg;
    logic [cfm_pkg::OPND_W-1:0]    out_right_reg;
    logic [cfm_pkg::VERDICT_W-1:0] verdict_reg;

    // RAM side
    logic [MAP_AW-1:0]         map_addr;
    logic [ID_AW-1:0]          id_addr;
    logic                      map_we, id_we;
    logic [MAP_AW-1:0]         map_waddr;
    logic [ID_AW-1:0]          id_waddr;
    logic [cfm_pkg::HIT_W-1:0] map_wdata, map_rdata;
    logic                      id_wdata, id_rdata;

    logic accept;
    logic out_free;
    logic need_out;
    logic commit;
    logic load_out;
    logic clr_map_hit, clr_id_hit;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Wrapped indexes, registered through the two reduce stages
    cfm_index_reduce #(.MOD(MAP_ENTRIES)) u_map_reduce (
        .aclk (aclk),
        .idx  (cov_index_reg),
        .rem  (map_addr)
    );

    cfm_index_reduce #(.MOD(ID_SPACE)) u_id_reduce (
        .aclk (aclk),
        .idx  (state_id_reg),
        .rem  (id_addr)
    );

    cfm_ram #(.DEPTH(MAP_ENTRIES), .WIDTH(cfm_pkg::HIT_W)) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_addr),
        .rdata (map_rdata)
    );

    cfm_ram #(.DEPTH(ID_SPACE), .WIDTH(1)) u_id_ram (
        .aclk  (aclk),
        .we    (id_we),
        .waddr (id_waddr),
        .wdata (id_wdata),
        .raddr (id_addr),
        .rdata (id_rdata)
    );

    // During the clearing pass the shorter RAM stops at its own depth
    assign clr_map_hit = ({1'b0, clr_cnt_reg} < (CLR_W+1)'(MAP_ENTRIES));
    assign clr_id_hit  = ({1'b0, clr_cnt_reg} < (CLR_W+1)'(ID_SPACE));

    // Does the item in the update state produce a result?
    always_comb begin
        unique case (cmd_reg)
            cfm_pkg::CMD_STATE: need_out = !id_rdata;
            cfm_pkg::CMD_END:   need_out = 1'b1;
            default:            need_out = 1'b0;
        endcase
    end

    // Commit once the output register can take the result; an item with no result commits at once
    assign commit   = (state_reg == ST_UPD) && (out_free || !need_out);
    assign load_out = commit && need_out;

    // Sequencer, flags and RAM write port
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        flags_next   = flags_reg;
        map_we       = 1'b0;
        map_waddr    = map_addr;
        map_wdata    = map_rdata | hit_reg;
        id_we        = 1'b0;
        id_waddr     = id_addr;
        id_wdata     = 1'b1;

        unique case (state_reg)
            ST_CLEAR: begin
                map_we       = clr_map_hit;
                map_waddr    = clr_cnt_reg[MAP_AW-1:0];
                map_wdata    = '0;
                id_we        = clr_id_hit;
                id_waddr     = clr_cnt_reg[ID_AW-1:0];
                id_wdata     = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(CLR_LEN - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_REM;
            ST_REM: state_next = ST_RD;
            ST_RD:  state_next = ST_UPD;
            ST_UPD: begin
                if (commit) begin
                    state_next = ST_IDLE;
                    unique case (cmd_reg)
                        cfm_pkg::CMD_COV: begin
                            map_we = 1'b1;
                            if (hit_reg > map_rdata) begin
                                flags_next[cfm_pkg::FLAG_COV] = 1'b1;
                            end
                        end
                        cfm_pkg::CMD_STATE: begin
                            // mark at once so a repeat within the run is dropped
                            if (!id_rdata) begin
                                id_we = 1'b1;
                                flags_next[cfm_pkg::FLAG_STATE] = 1'b1;
                            end
                        end
                        cfm_pkg::CMD_END: flags_next = '0;
                        default: ;  // unused command: no effect
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            flags_reg   <= flags_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Item latch
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg       <= s_command;
            cov_index_reg <= s_cov_index;
            hit_reg       <= s_cov_value;
            state_id_reg  <= s_state_id;
            op_reg        <= s_state_op;
            left_reg      <= s_left_operand;
            right_reg     <= s_right_operand;
        end
    end

    // Result payload: a record carries a zero verdict, a verdict zero record fields
    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (cmd_reg == cfm_pkg::CMD_END) begin
                kind_reg      <= cfm_pkg::KIND_VERDICT;
                out_id_reg    <= '0;
                out_op_reg    <= '0;
                out_left_reg  <= '0;
                out_right_reg <= '0;
                verdict_reg   <= flags_reg;
            end else begin
                kind_reg      <= cfm_pkg::KIND_RECORD;
                out_id_reg    <= cfm_pkg::IDX_W'(id_addr);
                out_op_reg    <= op_reg;
                out_left_reg  <= left_reg;
                out_right_reg <= right_reg;
                verdict_reg   <= '0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_out_id      = out_id_reg;
    assign m_out_op      = out_op_reg;
    assign m_out_left    = out_left_reg;
    assign m_out_right   = out_right_reg;
    assign m_verdict     = verdict_reg;

endmodule

>>> tb/coverage_feedback_merge_unit_tb.sv
// Testbench for the coverage feedback merge unit: scored random and directed feedback traffic.
`timescale 1ns / 1ps

module coverage_feedback_merge_unit_tb;

    // command 3 has no meaning; the block must drop it
    localparam logic [cfm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int unsigned MAP_SIZE    = cfm_pkg::MAP_ENTRIES_DEF;
    localparam int unsigned ID_SIZE     = cfm_pkg::ID_SPACE_DEF;
    localparam int          PER_PHASE   = 270;     // at least this many counted items per random phase
    localparam int          HOLD_CYCLES = 400;     // long receiver hold-off in phase 0
    localparam int          TAIL_CYCLES = 24;      // settle time after the last result
    // Clearing pass plus ~1200 items with the
    // worst gaps and stalls, taken several times over.
    localparam int          CYCLE_LIMIT = 600000;

    // One input item, every field at the port width.
    typedef struct packed {
        logic [cfm_pkg::CMD_W-1:0]  command;
        logic [cfm_pkg::IDX_W-1:0]  cov_index;
        logic [cfm_pkg::HIT_W-1:0]  cov_value;
        logic [cfm_pkg::IDX_W-1:0]  state_id;
        logic [cfm_pkg::OP_W-1:0]   state_op;
        logic [cfm_pkg::OPND_W-1:0] lhs;
        logic [cfm_pkg::OPND_W-1:0] rhs;
    } feed_item_t;

    // One result item: an appended state record or a run verdict.
    typedef struct packed {
        logic                          kind;
        logic [cfm_pkg::IDX_W-1:0]     id;
        logic [cfm_pkg::OP_W-1:0]      op;
        logic [cfm_pkg::OPND_W-1:0]    lhs;
        logic [cfm_pkg::OPND_W-1:0]    rhs;
        logic [cfm_pkg::VERDICT_W-1:0] verdict;
    } merge_result_t;

    logic                          aclk            = 1'b0;
    logic                          aresetn         = 1'b0;
    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic [cfm_pkg::CMD_W-1:0]     s_command       = '0;
    logic [cfm_pkg::IDX_W-1:0]     s_cov_index     = '0;
    logic [cfm_pkg::HIT_W-1:0]     s_cov_value     = '0;
    logic [cfm_pkg::IDX_W-1:0]     s_state_id      = '0;
    logic [cfm_pkg::OP_W-1:0]      s_state_op      = '0;
    logic [cfm_pkg::OPND_W-1:0]    s_left_operand  = '0;
    logic [cfm_pkg::OPND_W-1:0]    s_right_operand = '0;
    logic                          m_valid;
    logic                          m_ready         = 1'b0;
    logic                          m_result_kind;
    logic [cfm_pkg::IDX_W-1:0]     m_out_id;
    logic [cfm_pkg::OP_W-1:0]      m_out_op;
    logic [cfm_pkg::OPND_W-1:0]    m_out_left;
    logic [cfm_pkg::OPND_W-1:0]    m_out_right;
    logic [cfm_pkg::VERDICT_W-1:0] m_verdict;

    coverage_feedback_merge_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_cov_index     (s_cov_index),
        .s_cov_value     (s_cov_value),
        .s_state_id      (s_state_id),
        .s_state_op      (s_state_op),
        .s_left_operand  (s_left_operand),
        .s_right_operand (s_right_operand),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_out_id        (m_out_id),
        .m_out_op        (m_out_op),
        .m_out_left      (m_out_left),
        .m_out_right     (m_out_right),
        .m_verdict       (m_verdict)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow state of the block: persistent map, seen ids, per-run flags
    // ------------------------------------------------------------------
    logic [cfm_pkg::HIT_W-1:0]     hit_map [MAP_SIZE];
    logic                          id_seen [ID_SIZE];
    logic [cfm_pkg::VERDICT_W-1:0] run_flags;

    feed_item_t    feed_queue [$];     // items waiting for the driver
    merge_result_t owed_results [$];   // records and verdicts the block still owes
    int            items_queued = 0;
    int            items_taken  = 0;
    int            mismatches   = 0;
    int            cycles       = 0;

    logic          in_taken     = 1'b0;  // driver's item was accepted at the last edge
    int            send_gap_pct   = 0;
    int            recv_stall_pct = 0;
    logic          hold_arm     = 1'b0;
    logic          hold_done    = 1'b0;
    int            hold_left    = 0;

    // Merge one accepted item into the shadow state; returns 1 when it owes a result.
    // 16-bit index and id wrap naturally onto the 64K-entry stores.
    function automatic bit apply_feedback_item(input feed_item_t it,
                                               output merge_result_t res);
        res = '0;
        case (it.command)
            cfm_pkg::CMD_COV: begin
                // strictly larger byte means a new hit count bucket
                if (it.cov_value > hit_map[it.cov_index])
                    run_flags[cfm_pkg::FLAG_COV] = 1'b1;
                hit_map[it.cov_index] = hit_map[it.cov_index] | it.cov_value;
                return 1'b0;
            end
            cfm_pkg::CMD_STATE: begin
                // already seen: dropped, flags untouched
                if (id_seen[it.state_id])
                    return 1'b0;
                // marked at once, so a repeat later in the same run is dropped too
                id_seen[it.state_id]   = 1'b1;
                run_flags[cfm_pkg::FLAG_STATE] = 1'b1;
                res.kind = cfm_pkg::KIND_RECORD;
                res.id   = it.state_id;
                res.op   = it.state_op;
                res.lhs  = it.lhs;
                res.rhs  = it.rhs;
                return 1'b1;
            end
            cfm_pkg::CMD_END: begin
                res.kind    = cfm_pkg::KIND_VERDICT;
                res.verdict = run_flags;
                run_flags   = '0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("MISMATCH @%0t %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers. Fields that the command does not use are random,
    // so every bit of every field toggles across the run.
    // ------------------------------------------------------------------
    function automatic feed_item_t random_item(input logic [cfm_pkg::CMD_W-1:0] cmd);
        feed_item_t it;
        it.command   = cmd;
        it.cov_index = cfm_pkg::IDX_W'($urandom);
        it.cov_value = cfm_pkg::HIT_W'($urandom);
        it.state_id  = cfm_pkg::IDX_W'($urandom);
        it.state_op  = cfm_pkg::OP_W'($urandom);
        it.lhs       = {$urandom, $urandom};
        it.rhs       = {$urandom, $urandom};
        return it;
    endfunction

    task automatic queue_item(input feed_item_t it);
        feed_queue.push_back(it);
        items_queued++;
    endtask

    task automatic queue_cov(input logic [cfm_pkg::IDX_W-1:0] idx,
                             input logic [cfm_pkg::HIT_W-1:0] val);
        feed_item_t it;
        it           = random_item(cfm_pkg::CMD_COV);
        it.cov_index = idx;
        it.cov_value = val;
        queue_item(it);
    endtask

    task automatic queue_state(input logic [cfm_pkg::IDX_W-1:0] id,
                               input logic [cfm_pkg::OP_W-1:0] op,
                               input logic [cfm_pkg::OPND_W-1:0] lhs,
                               input logic [cfm_pkg::OPND_W-1:0] rhs);
        feed_item_t it;
        it          = random_item(cfm_pkg::CMD_STATE);
        it.state_id = id;
        it.state_op = op;
        it.lhs      = lhs;
        it.rhs      = rhs;
        queue_item(it);
    endtask

    // One fuzzer run: coverage bytes and state records in random order, then
    // end of run. A few runs are broken (no end, so they merge into the next
    // run) and some carry unused-command noise, which is not counted.
    task automatic queue_run(output int counted);
        int                        n_cov;
        int                        n_state;
        int                        r;
        logic [cfm_pkg::IDX_W-1:0] id;
        logic [cfm_pkg::IDX_W-1:0] idx;
        logic [cfm_pkg::HIT_W-1:0] val;
        logic [cfm_pkg::IDX_W-1:0] run_ids [$];
        n_cov   = $urandom_range(8);
        n_state = $urandom_range(4);
        counted = 0;
        while (n_cov + n_state > 0) begin
            if ($urandom_range(99) < 4)
                queue_item(random_item(CMD_UNUSED));
            if ($urandom_range(n_cov + n_state - 1) < n_cov) begin
                // hot region gives repeated positions, so old and new hits mix
                idx = ($urandom_range(1)) ? cfm_pkg::IDX_W'($urandom_range(63))
                                          : cfm_pkg::IDX_W'($urandom);
                r   = $urandom_range(3);
                val = (r == 0) ? cfm_pkg::HIT_W'(1 << $urandom_range(7))
                               : cfm_pkg::HIT_W'($urandom);
                queue_cov(idx, val);
                n_cov--;
            end else begin
                r = $urandom_range(99);
                if (r < 35)
                    id = cfm_pkg::IDX_W'($urandom_range(31));  // small pool: mostly seen
                else if (r < 50 && run_ids.size() != 0)
                    id = run_ids[$urandom_range(run_ids.size() - 1)];  // repeat in run
                else
                    id = cfm_pkg::IDX_W'($urandom);
                run_ids.push_back(id);
                queue_state(id, cfm_pkg::OP_W'($urandom), {$urandom, $urandom},
                            {$urandom, $urandom});
                n_state--;
            end
            counted++;
        end
        r = $urandom_range(99);
        if (r >= 8) begin
            queue_item(random_item(cfm_pkg::CMD_END));
            counted++;
        end
        if (r >= 96) begin
            // back-to-back end: verdict of an empty run
            queue_item(random_item(cfm_pkg::CMD_END));
            counted++;
        end
    endtask

    // All queued items accepted and every owed result received.
    task automatic wait_drained();
        do @(negedge aclk);
        while (items_taken != items_queued || owed_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Driver: new items go out at the falling edge; valid holds until taken.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        feed_item_t it;
        if (!s_valid || in_taken) begin
            if (feed_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                it = feed_queue.pop_front();
                s_valid         <= 1'b1;
                s_command       <= it.command;
                s_cov_index     <= it.cov_index;
                s_cov_value     <= it.cov_value;
                s_state_id      <= it.state_id;
                s_state_op      <= it.state_op;
                s_left_operand  <= it.lhs;
                s_right_operand <= it.rhs;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, armed once; the sender keeps offering meanwhile
    // so the block's pipeline backs up into s_ready.
    always @(negedge aclk) begin
        if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= aresetn && (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge. The input side
    // is handled first so the scoreboard stays ordered.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        feed_item_t    seen;
        merge_result_t want;
        merge_result_t got;
        in_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen = {s_command, s_cov_index, s_cov_value, s_state_id, s_state_op,
                        s_left_operand, s_right_operand};
                items_taken++;
                if (apply_feedback_item(seen, want))
                    owed_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = {m_result_kind, m_out_id, m_out_op, m_out_left, m_out_right,
                       m_verdict};
                if (owed_results.size() == 0) begin
                    flag_mismatch("result with nothing owed, kind/id",
                                  64'({got.kind, got.id}), '0);
                end else begin
                    want = owed_results.pop_front();
                    if (got.kind !== want.kind)
                        flag_mismatch("result_kind", 64'(got.kind), 64'(want.kind));
                    if (got.id !== want.id)
                        flag_mismatch("out_id", 64'(got.id), 64'(want.id));
                    if (got.op !== want.op)
                        flag_mismatch("out_op", 64'(got.op), 64'(want.op));
                    if (got.lhs !== want.lhs)
                        flag_mismatch("out_left", got.lhs, want.lhs);
                    if (got.rhs !== want.rhs)
                        flag_mismatch("out_right", got.rhs, want.rhs);
                    if (got.verdict !== want.verdict)
                        flag_mismatch("verdict", 64'(got.verdict), 64'(want.verdict));
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results still owed", cycles,
                     owed_results.size());
            $display("** coverage_feedback_merge_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int send_pct_tab  [4] = '{0, 60, 0, 12};
    int stall_pct_tab [4] = '{0, 0, 60, 12};

    initial begin
        int ph;
        int sent;
        int n;

        // shadow reset matches the block's clearing pass
        foreach (hit_map[i]) hit_map[i] = '0;
        foreach (id_seen[i]) id_seen[i] = 1'b0;
        run_flags = '0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part
        queue_cov(16'h0000, 8'h00);                  // zero byte on empty entry: not new
        queue_item(random_item(cfm_pkg::CMD_END));   // verdict 0
        queue_cov(16'hFFFF, 8'hFF);                  // top index, full byte: new
        queue_cov(16'hFFFF, 8'hFF);                  // same again: not new
        queue_item(random_item(cfm_pkg::CMD_END));   // verdict: coverage
        queue_cov(16'h1234, 8'h0F);
        queue_item(random_item(cfm_pkg::CMD_END));
        queue_cov(16'h1234, 8'hF0);                  // larger, disjoint bits: new
        queue_cov(16'h1234, 8'h80);                  // below merged entry: not new
        queue_item(random_item(cfm_pkg::CMD_END));
        queue_state(16'h0000, 8'h00, '0, '0);        // lowest id, zero payload
        queue_state(16'hFFFF, 8'hFF, '1, '1);        // highest id, all-ones payload
        queue_state(16'hFFFF, 8'h5A, {$urandom, $urandom}, '0);  // repeat in same run
        queue_item(random_item(cfm_pkg::CMD_END));   // verdict: state only
        queue_state(16'h0000, 8'h33, '1, '0);        // seen in an earlier run
        queue_cov(16'h1234, 8'h01);                  // entry saturated
        queue_item(random_item(cfm_pkg::CMD_END));   // verdict 0
        queue_item(random_item(CMD_UNUSED));         // ignored command
        queue_item(random_item(cfm_pkg::CMD_END));
        queue_cov(16'h00AA, 8'h55);
        queue_state(16'h5A5A, 8'hC3, {$urandom, $urandom}, {$urandom, $urandom});
        queue_item(random_item(cfm_pkg::CMD_END));   // verdict: both flags
        wait_drained();

        // Random part: no idling (with the long hold-off), sender gaps,
        // receiver stalls, then light idling on both sides.
        for (ph = 0; ph < 4; ph++) begin
            @(posedge aclk);
            send_gap_pct   = send_pct_tab[ph];
            recv_stall_pct = stall_pct_tab[ph];
            if (ph == 0)
                hold_arm = 1'b1;
            sent = 0;
            while (sent < PER_PHASE) begin
                queue_run(n);
                sent += n;
            end
            // close any broken run so the phase ends on a verdict
            queue_item(random_item(cfm_pkg::CMD_END));
            wait_drained();
        end

        // catch any stray result the block might still emit
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0)
            $display("** coverage_feedback_merge_unit: PASSED **");
        else
            $display("** coverage_feedback_merge_unit: FAILED **");
        $finish;
    end

endmodule
